FILE: rtl/core/neighbor_label_frequency_bitmap_macros.svh
// Assertion helpers for the neighbor label frequency bitmap block.
// All checks are sampled on i_clk and are off while i_rst_n is low.
`ifndef NEIGHBOR_LABEL_FREQUENCY_BITMAP_MACROS_SVH
`define NEIGHBOR_LABEL_FREQUENCY_BITMAP_MACROS_SVH

// same-cycle implication
`define NLFB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NLFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nlfb_pkg.sv
`timescale 1ns / 1ps

package nlfb_pkg;

    localparam int NUM_LABELS_DEF     = 32;
    localparam int BITS_PER_LABEL_DEF = 8;
    localparam int NLF_WORDS_DEF      = 4;
    localparam int DEGREE_BITS_DEF    = 16;

    localparam int LABEL_W  = 5;
    localparam int DEGREE_W = 16;
    localparam int INDEX_W  = 2;
    localparam int WORD_W   = 64;

    typedef struct packed {
        logic [LABEL_W-1:0]  neighbor_label;
        logic [DEGREE_W-1:0] neighbor_degree;
        logic                last_neighbor;
        logic                empty_vertex;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_W-1:0]  word_index;
        logic [WORD_W-1:0]   bitmap_word;
        logic [DEGREE_W-1:0] max_neighbor_degree;
        logic                last_word;
    } t_out_word;

endpackage

FILE: rtl/core/neighbor_label_frequency_bitmap.sv
`timescale 1ns / 1ps
// The result words of a vertex are loaded into the output frame register as its last
// neighbor (or empty-vertex word) leaves the input register, and go out one per cycle
// while i_out_ready is high. Throughput: one neighbor per cycle, unless held as below.
// A vertex-ending word waits in the input register while the previous NLF_WORDS
// result words drain from the output frame register.
// Reset (synchronous, active low) clears all label counts, the bitmap and the maximum.
`include "neighbor_label_frequency_bitmap_macros.svh"

module neighbor_label_frequency_bitmap #(
    parameter int NUM_LABELS     = nlfb_pkg::NUM_LABELS_DEF,
    parameter int BITS_PER_LABEL = nlfb_pkg::BITS_PER_LABEL_DEF,
    parameter int NLF_WORDS      = nlfb_pkg::NLF_WORDS_DEF,
    parameter int DEGREE_BITS    = nlfb_pkg::DEGREE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  nlfb_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output nlfb_pkg::t_out_word o_out_data
);

    localparam int WORD_W     = nlfb_pkg::WORD_W;
    localparam int TOTAL_BITS = NLF_WORDS * WORD_W;
    localparam int LBL_W      = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam int CNT_W      = $clog2(BITS_PER_LABEL + 1);
    localparam int BIT_W      = $clog2(NUM_LABELS * BITS_PER_LABEL) + 1;
    localparam int WC_W       = (NLF_WORDS > 1) ? $clog2(NLF_WORDS) : 1;
    localparam int MAX_W      = (DEGREE_BITS < nlfb_pkg::DEGREE_W) ? DEGREE_BITS
                                                                   : nlfb_pkg::DEGREE_W;

    // input register
    logic               r_in_valid;
    nlfb_pkg::t_in_word r_in;

    // per-vertex accumulation state
    logic [CNT_W-1:0]      r_counts [NUM_LABELS];
    logic [CNT_W-1:0]      n_counts [NUM_LABELS];
    logic [TOTAL_BITS-1:0] r_bitmap;
    logic [TOTAL_BITS-1:0] n_bitmap;
    logic [MAX_W-1:0]      r_max;
    logic [MAX_W-1:0]      n_max;

    // output frame, words stored in emission order
    logic [WORD_W-1:0] r_frame [NLF_WORDS];
    logic [WORD_W-1:0] n_frame [NLF_WORDS];
    logic [MAX_W-1:0]  r_frame_max;
    logic [MAX_W-1:0]  n_frame_max;
    logic              r_frame_valid;
    logic [WC_W-1:0]   r_word_cnt;

    logic                  lab_ok;
    logic [LBL_W-1:0]      lab_idx;
    logic [CNT_W-1:0]      cur_cnt;
    logic                  cnt_sat;
    logic [BIT_W-1:0]      bit_pos;
    logic [MAX_W-1:0]      deg_m;
    logic [TOTAL_BITS-1:0] upd_bitmap;
    logic [MAX_W-1:0]      upd_max;
    logic                  ends_vertex;
    logic                  out_take;
    logic                  out_last;
    logic                  frame_free;
    logic                  proc_go;
    logic                  in_take;

    assign in_take     = i_in_valid && o_in_ready;
    assign out_last    = (int'(r_word_cnt) == NLF_WORDS - 1);
    assign out_take    = o_out_valid && i_out_ready;
    assign frame_free  = !r_frame_valid || (out_take && out_last);
    assign ends_vertex = r_in.empty_vertex || r_in.last_neighbor;
    assign proc_go     = r_in_valid && (!ends_vertex || frame_free);
    assign o_in_ready  = !r_in_valid || proc_go;

    always_comb begin
        lab_ok  = int'(r_in.neighbor_label) < NUM_LABELS;
        lab_idx = LBL_W'(r_in.neighbor_label);
        cur_cnt = r_counts[lab_idx];
        cnt_sat = int'(cur_cnt) >= BITS_PER_LABEL;
        bit_pos = BIT_W'(r_in.neighbor_label) * BIT_W'(BITS_PER_LABEL) + BIT_W'(cur_cnt);
        deg_m   = r_in.neighbor_degree[MAX_W-1:0];
        upd_max = (deg_m > r_max) ? deg_m : r_max;

        n_counts   = r_counts;
        upd_bitmap = r_bitmap;
        if (lab_ok && !cnt_sat) begin
            n_counts[lab_idx] = cur_cnt + CNT_W'(1);
            // bits past the end of the bitmap are dropped, count still rises
            if (int'(bit_pos) < TOTAL_BITS) begin
                upd_bitmap = r_bitmap | (TOTAL_BITS'(1) << bit_pos);
            end
        end
        n_bitmap = upd_bitmap;
        n_max    = upd_max;

        if (r_in.empty_vertex) begin
            n_frame_max = '0;
            for (int k = 0; k < NLF_WORDS; k++) begin
                n_frame[k] = '0;
            end
        end else begin
            n_frame_max = upd_max;
            for (int k = 0; k < NLF_WORDS; k++) begin
                n_frame[k] = upd_bitmap[(NLF_WORDS-1-k)*WORD_W +: WORD_W];
            end
        end

        if (ends_vertex) begin
            n_bitmap = '0;
            n_max    = '0;
            for (int i = 0; i < NUM_LABELS; i++) begin
                n_counts[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap <= '0;
            r_max    <= '0;
            for (int i = 0; i < NUM_LABELS; i++) begin
                r_counts[i] <= '0;
            end
        end else if (proc_go) begin
            r_bitmap <= n_bitmap;
            r_max    <= n_max;
            r_counts <= n_counts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= 1'b0;
            r_word_cnt    <= '0;
        end else if (proc_go && ends_vertex) begin
            r_frame_valid <= 1'b1;
            r_word_cnt    <= '0;
        end else if (out_take) begin
            if (out_last) begin
                r_frame_valid <= 1'b0;
                r_word_cnt    <= '0;
            end else begin
                r_word_cnt <= r_word_cnt + WC_W'(1);
            end
        end
        if (proc_go && ends_vertex) begin
            r_frame     <= n_frame;
            r_frame_max <= n_frame_max;
        end
    end

    assign o_out_valid                    = r_frame_valid;
    assign o_out_data.word_index          = nlfb_pkg::INDEX_W'(r_word_cnt);
    assign o_out_data.bitmap_word         = r_frame[r_word_cnt];
    assign o_out_data.max_neighbor_degree = nlfb_pkg::DEGREE_W'(r_frame_max);
    assign o_out_data.last_word           = out_last;

    `NLFB_ASSERT_NOW(a_end_waits_for_frame, proc_go && ends_vertex, frame_free, "vertex end overran a pending frame")
    `NLFB_ASSERT_NEXT(a_frame_loads, proc_go && ends_vertex, r_frame_valid && r_word_cnt == '0, "frame not started after vertex end")
    `NLFB_ASSERT_NEXT(a_state_clears, proc_go && ends_vertex, r_max == '0 && r_bitmap == '0, "state not cleared after vertex end")
    `NLFB_ASSERT_NEXT(a_frame_drains, out_take && out_last && !(proc_go && ends_vertex), !r_frame_valid, "frame still valid after its last word")
    `NLFB_ASSERT_NOW(a_cnt_in_range, r_frame_valid, int'(r_word_cnt) < NLF_WORDS, "word counter past frame")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NUM_LABELS     = nlfb_pkg::NUM_LABELS_DEF;
    localparam int BITS_PER_LABEL = nlfb_pkg::BITS_PER_LABEL_DEF;
    localparam int NLF_WORDS      = nlfb_pkg::NLF_WORDS_DEF;
    localparam int DEGREE_BITS    = nlfb_pkg::DEGREE_BITS_DEF;
    localparam int LABEL_W        = nlfb_pkg::LABEL_W;
    localparam int DEGREE_W       = nlfb_pkg::DEGREE_W;
    localparam int INDEX_W        = nlfb_pkg::INDEX_W;
    localparam int WORD_W         = nlfb_pkg::WORD_W;
    localparam int MAP_BITS       = NLF_WORDS * WORD_W;
    localparam logic [DEGREE_W-1:0] DEGREE_MASK = DEGREE_W'((64'd1 << DEGREE_BITS) - 1);

    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        nlfb_pkg::t_in_word  stim;
        bit                  typed;
        logic [MAP_BITS-1:0] map;
        logic [DEGREE_W-1:0] deg;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    nlfb_pkg::t_in_word  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    nlfb_pkg::t_out_word out_data;

    // predictor state
    logic [3:0]          label_count [NUM_LABELS];
    logic [MAP_BITS-1:0] label_map;
    logic [DEGREE_W-1:0] max_degree;

    nlfb_pkg::t_out_word pending_bitmap_words[$];
    t_row                stim_plan[$];
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    int                  burst_left = 0;
    int                  cycle_count = 0;
    bit                  hold_req = 1'b0;

    neighbor_label_frequency_bitmap dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic clear_vertex();
        foreach (label_count[i]) label_count[i] = '0;
        label_map  = '0;
        max_degree = '0;
    endtask

    task automatic queue_frame(input logic [MAP_BITS-1:0] map, input logic [DEGREE_W-1:0] deg);
        nlfb_pkg::t_out_word w;
        for (int k = 0; k < NLF_WORDS; k++) begin
            w.word_index          = INDEX_W'(k);
            // word 0 carries the top of the bitmap
            w.bitmap_word         = map[WORD_W*(NLF_WORDS-1-k) +: WORD_W];
            w.max_neighbor_degree = deg;
            w.last_word           = (k == NLF_WORDS - 1);
            pending_bitmap_words.push_back(w);
        end
    endtask

    task automatic track_neighbor(input nlfb_pkg::t_in_word w, input bit emit);
        logic [DEGREE_W-1:0] d;
        int                  bit_pos;
        if (w.empty_vertex) begin
            if (emit) queue_frame('0, '0);
            clear_vertex();
            return;
        end
        d = w.neighbor_degree & DEGREE_MASK;
        if (d > max_degree) max_degree = d;
        if (w.neighbor_label < NUM_LABELS && label_count[w.neighbor_label] < BITS_PER_LABEL) begin
            bit_pos = w.neighbor_label * BITS_PER_LABEL + label_count[w.neighbor_label];
            if (bit_pos < MAP_BITS) label_map[bit_pos] = 1'b1;
            label_count[w.neighbor_label] += 1'b1;
        end
        if (w.last_neighbor) begin
            if (emit) queue_frame(label_map, max_degree);
            clear_vertex();
        end
    endtask

    task automatic add_row(input int label, input int degree, input bit last, input bit empty,
                           input bit typed, input logic [MAP_BITS-1:0] map, input int deg);
        t_row r;
        r.stim.neighbor_label  = LABEL_W'(label);
        r.stim.neighbor_degree = DEGREE_W'(degree);
        r.stim.last_neighbor   = last;
        r.stim.empty_vertex    = empty;
        r.typed                = typed;
        r.map                  = map;
        r.deg                  = DEGREE_W'(deg);
        stim_plan.push_back(r);
    endtask

    // offer one word, predict on acceptance, then maybe take a gap
    task automatic push_item(input t_row r);
        in_valid <= 1'b1;
        in_data  <= r.stim;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (r.typed) begin
            track_neighbor(r.stim, 1'b0);
            queue_frame(r.map, r.deg);
        end else begin
            track_neighbor(r.stim, 1'b1);
        end
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    function automatic logic [DEGREE_W-1:0] rand_degree();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return DEGREE_W'($urandom);
        endcase
    endfunction

    task automatic send_vertex();
        t_row                r;
        int                  n;
        int                  pool;
        bit                  broken;
        logic [LABEL_W-1:0]  base;
        // mostly short vertices; a narrow label pool drives counts into saturation
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        pool   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : NUM_LABELS;
        base   = LABEL_W'($urandom);
        broken = ($urandom_range(0, 15) == 0);
        r.typed = 1'b0;
        r.map   = '0;
        r.deg   = '0;
        for (int i = 0; i < n; i++) begin
            r.stim.neighbor_label  = (pool == NUM_LABELS) ? LABEL_W'($urandom)
                                   : base + LABEL_W'($urandom_range(0, pool - 1));
            r.stim.neighbor_degree = rand_degree();
            r.stim.last_neighbor   = (i == n - 1);
            r.stim.empty_vertex    = 1'b0;
            if (broken && i == n - 1) begin
                r.stim.empty_vertex  = 1'b1;
                r.stim.last_neighbor = 1'(($urandom));
            end
            push_item(r);
        end
    endtask

    task automatic note_mismatch(input string what, input nlfb_pkg::t_out_word exp,
                                 input nlfb_pkg::t_out_word got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: exp idx=%0d map=%h deg=%h last=%b, got idx=%0d map=%h deg=%h last=%b",
                     $realtime, what, exp.word_index, exp.bitmap_word, exp.max_neighbor_degree,
                     exp.last_word, got.word_index, got.bitmap_word, got.max_neighbor_degree,
                     got.last_word);
    endtask

    always @(posedge i_clk) begin
        nlfb_pkg::t_out_word exp;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_bitmap_words.size() == 0) begin
                note_mismatch("unexpected word", '0, out_data);
            end else begin
                exp = pending_bitmap_words.pop_front();
                if (out_data.word_index !== exp.word_index
                        || out_data.bitmap_word !== exp.bitmap_word
                        || out_data.max_neighbor_degree !== exp.max_neighbor_degree
                        || out_data.last_word !== exp.last_word)
                    note_mismatch("word mismatch", exp, out_data);
            end
        end
    end

    // receiver: mode changes every so often, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(10, 60);
                end
                span--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom);
                    2: out_ready <= ($urandom_range(0, 7) != 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_row r;
        bit   hold_done;
        bit   pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        clear_vertex();

        // empty vertex straight out of reset
        add_row(0, 0, 0, 1, 1, '0, 0);
        // lowest label, top degree
        add_row(0, 16'hFFFF, 1, 0, 1, MAP_BITS'(1), 16'hFFFF);
        // highest label lands in the top word
        add_row(31, 0, 1, 0, 1, MAP_BITS'(1) << 248, 0);
        // nine hits on one label: count saturates after eight
        for (int i = 0; i < 9; i++)
            add_row(5, i * 100, i == 8, 0, i == 8, MAP_BITS'(8'hFF) << 40, 800);
        // half-built vertex thrown away by an empty vertex
        add_row(7, 100, 0, 0, 0, '0, 0);
        add_row(9, 16'h1234, 0, 1, 1, '0, 0);
        // empty and last together
        add_row(31, 16'hFFFF, 1, 1, 1, '0, 0);
        // labels on the word boundaries
        add_row(15, 16'h8000, 0, 0, 0, '0, 0);
        add_row(16, 1, 0, 0, 0, '0, 0);
        add_row(31, 16'h7FFF, 0, 0, 0, '0, 0);
        add_row(31, 0, 0, 0, 0, '0, 0);
        add_row(24, 2, 0, 0, 0, '0, 0);
        add_row(23, 1, 1, 0, 0, '0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_plan[i]) push_item(stim_plan[i]);

        r.typed = 1'b0;
        r.map   = '0;
        r.deg   = '0;
        while (items_sent < stim_plan.size() + RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= stim_plan.size() + 40) begin
                hold_done  = 1'b1;
                hold_req   = 1'b1;
                burst_left = 40;
            end
            if (!pause_done && items_sent >= stim_plan.size() + 120) begin
                pause_done = 1'b1;
                if (pending_bitmap_words.size() != 0) begin
                    in_valid <= 1'b0;
                    while (pending_bitmap_words.size() != 0) @(posedge i_clk);
                end
            end
            if ($urandom_range(0, 11) == 0) begin
                // stray empty vertex with junk neighbor fields
                r.stim.neighbor_label  = LABEL_W'($urandom);
                r.stim.neighbor_degree = rand_degree();
                r.stim.last_neighbor   = 1'($urandom);
                r.stim.empty_vertex    = 1'b1;
                push_item(r);
            end else begin
                send_vertex();
            end
        end

        in_valid <= 1'b0;
        while (pending_bitmap_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bitmap_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
